@@ design/slc_pkg.sv @@
// Shared types, constants and command codes of the PCM nearest-level slicer.
package slc_pkg;

   localparam int PHASES   = 6;
   localparam int LEVELS   = 128;
   localparam int PHASE_W  = 3;
   localparam int IDX_W    = 7;
   localparam int ADDR_W   = PHASE_W + IDX_W;
   localparam int LVL_W    = 15;
   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 8;

   // Commands carried by a request beat
   typedef enum logic [1:0] {
      CMD_DECIDE    = 2'd0,
      CMD_WR_LEVEL  = 2'd1,
      CMD_WR_ROW    = 2'd2,
      CMD_SET_PHASE = 2'd3
   } cmd_type;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_TEST   = 6'b000100,
      ST_FETCH0 = 6'b001000,
      ST_FETCH1 = 6'b010000,
      ST_PICK   = 6'b100000
   } state_type;

   // Result of the shared compare/distance unit
   typedef struct packed {
      logic             ge;
      logic [LVL_W-1:0] gap;
   } diff_type;

endpackage

@@ design/pcm_nearest_level_slicer.sv @@
// Top level of the PCM nearest-level slicer: sequencer, phase state and result register.
//
// Request channel (req_*): one beat carries a command. Decide slices
// req_sample against the current phase's level table; the write commands
// load a table level or a row length and doubling flag; set-phase loads
// the current phase. Only decide produces a response beat.
// Response channel (rsp_*): the signed level, its code, the sign bit and
// the phase used. Both channels use valid/ready.
// Write and set-phase beats complete on acceptance; the next beat may follow at once.
// A decide beat walks the phase's table one entry per cycle through a
// single read port of the level memory and one shared compare/distance
// unit: READ issues the first read, TEST steps over entries of the scan,
// and FETCH0, FETCH1 and PICK fetch and compare the two neighbor levels.
// req_ready is low while a decide is in progress.
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls with a response pending, a finished
// decide holds in its last step until the register frees up.
// Reset clears row lengths, doubling flags, the phase and the sequencer;
// the level table is undefined until written.
module pcm_nearest_level_slicer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_command,
   input  logic signed [15:0]             req_sample,
   input  logic [2:0]                     req_phase_index,
   input  logic [6:0]                     req_level_index,
   input  logic [14:0]                    req_level_value,
   input  logic [7:0]                     req_row_length,
   input  logic                           req_double_flag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [15:0]             rsp_decided_level,
   output logic [6:0]                     rsp_level_code,
   output logic                           rsp_sign_bit,
   output logic [2:0]                     rsp_used_phase
);

   localparam int PW = slc_pkg::PHASE_W;
   localparam int IW = slc_pkg::IDX_W;
   localparam int LW = slc_pkg::LVL_W;
   localparam int SW = slc_pkg::SAMPLE_W;
   localparam int NW = slc_pkg::LEN_W + 1;

   slc_pkg::state_type state_ff, state_in;

   logic [slc_pkg::LEN_W-1:0] row_len_ff [0:slc_pkg::PHASES-1];
   logic                      dbl_ff     [0:slc_pkg::PHASES-1];
   logic [PW-1:0]             phase_ff;

   // Working registers of one decide
   logic [PW-1:0] ph_ff, ph_in;
   logic [LW-1:0] mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic          wdbl_ff, wdbl_in;
   logic [IW-1:0] last_ff, last_in;
   logic [IW-1:0] code_ff, code_in;
   logic [LW-1:0] lvl0_ff, lvl0_in;
   logic [LW-1:0] e0_ff, e0_in;

   // Response register
   logic          rsp_valid_ff;
   logic [SW-1:0] out_level_ff;
   logic [IW-1:0] out_code_ff;
   logic          out_sign_ff;
   logic [PW-1:0] out_phase_ff;

   logic              req_fire;
   logic              out_free;
   logic              load_out;
   slc_pkg::cmd_type  cmd;
   logic              ph_ok;
   logic              mem_rd_en;
   logic [IW-1:0]     mem_rd_idx;
   logic [LW-1:0]     mem_rd_data;
   slc_pkg::diff_type dres;
   logic [NW-1:0]     n_raw;
   logic [NW-1:0]     n_lim;
   logic [NW-1:0]     n_last;
   logic [SW-1:0]     s_neg;
   logic [IW-1:0]     pick_code;
   logic [LW-1:0]     pick_lvl;
   logic [SW-1:0]     pick_signed;
   logic [SW-1:0]     pick_neg;

   assign cmd       = slc_pkg::cmd_type'(req_command);
   assign req_ready = (state_ff == slc_pkg::ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign ph_ok     = (req_phase_index < PW'(slc_pkg::PHASES));
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign load_out  = (state_ff == slc_pkg::ST_PICK) & out_free;

   slc_level_mem u_mem (
      .clock   (clock),
      .wr_en   (req_fire & (cmd == slc_pkg::CMD_WR_LEVEL) & ph_ok),
      .wr_addr ({req_phase_index, req_level_index}),
      .wr_data (req_level_value),
      .rd_en   (mem_rd_en),
      .rd_addr ({ph_ff, mem_rd_idx}),
      .rd_data (mem_rd_data)
   );

   slc_abs_diff u_diff (
      .level  (mem_rd_data),
      .mag    (mag_ff),
      .result (dres)
   );

   // Scan bound of the current phase and magnitude of an incoming sample
   always_comb begin
      n_raw = dbl_ff[phase_ff] ? {row_len_ff[phase_ff], 1'b0} : {1'b0, row_len_ff[phase_ff]};
      n_lim = n_raw;
      if (n_raw > NW'(slc_pkg::LEVELS)) begin
         n_lim = NW'(slc_pkg::LEVELS);
      end
      if (n_raw == '0) begin
         n_lim = NW'(1);
      end
      n_last = n_lim - NW'(1);
      s_neg  = (~req_sample) + SW'(1);
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in   = state_ff;
      ph_in      = ph_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      wdbl_in    = dbl_ff[phase_ff];
      last_in    = last_ff;
      code_in    = code_ff;
      lvl0_in    = lvl0_ff;
      e0_in      = e0_ff;
      mem_rd_en  = 1'b0;
      mem_rd_idx = code_ff;
      pick_code  = code_ff;
      pick_lvl   = lvl0_ff;
      case (state_ff)
         slc_pkg::ST_IDLE: begin
            if (req_fire && cmd == slc_pkg::CMD_DECIDE) begin
               ph_in   = phase_ff;
               neg_in  = req_sample[SW-1];
               if (!req_sample[SW-1]) begin
                  mag_in = req_sample[LW-1:0];
               end else if (req_sample[LW-1:0] == '0) begin
                  mag_in = '1;
               end else begin
                  mag_in = s_neg[LW-1:0];
               end
               last_in  = n_last[IW-1:0];
               code_in  = '0;
               state_in = slc_pkg::ST_READ;
            end else begin
               wdbl_in = wdbl_ff;
            end
         end
         slc_pkg::ST_READ: begin
            wdbl_in   = wdbl_ff;
            mem_rd_en = 1'b1;
            state_in  = slc_pkg::ST_TEST;
         end
         slc_pkg::ST_TEST: begin
            wdbl_in = wdbl_ff;
            if (code_ff < last_ff && dres.ge) begin
               code_in    = code_ff + IW'(1);
               mem_rd_en  = 1'b1;
               mem_rd_idx = code_ff + IW'(1);
            end else begin
               code_in  = (code_ff != '0) ? code_ff - IW'(1) : '0;
               state_in = slc_pkg::ST_FETCH0;
            end
         end
         slc_pkg::ST_FETCH0: begin
            wdbl_in   = wdbl_ff;
            mem_rd_en = 1'b1;
            state_in  = slc_pkg::ST_FETCH1;
         end
         slc_pkg::ST_FETCH1: begin
            wdbl_in    = wdbl_ff;
            lvl0_in    = mem_rd_data;
            e0_in      = dres.gap;
            mem_rd_en  = 1'b1;
            mem_rd_idx = code_ff + IW'(1);
            state_in   = slc_pkg::ST_PICK;
         end
         slc_pkg::ST_PICK: begin
            wdbl_in = wdbl_ff;
            // Upper neighbor wins only when strictly nearer
            if (dres.gap < e0_ff) begin
               pick_code = code_ff + IW'(1);
               pick_lvl  = mem_rd_data;
            end
            if (out_free) begin
               state_in = slc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slc_pkg::ST_IDLE;
         end
      endcase
      pick_signed = {1'b0, pick_lvl};
      pick_neg    = (~pick_signed) + SW'(1);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slc_pkg::ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < slc_pkg::PHASES; i++) begin
            row_len_ff[i] <= '0;
            dbl_ff[i]     <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         // Apply table and phase commands
         if (req_fire && ph_ok && cmd == slc_pkg::CMD_WR_ROW) begin
            row_len_ff[req_phase_index] <= req_row_length;
            dbl_ff[req_phase_index]     <= req_double_flag;
         end
         if (req_fire && ph_ok && cmd == slc_pkg::CMD_SET_PHASE) begin
            phase_ff <= req_phase_index;
         end
         // Advance the phase when a decision completes
         if (load_out) begin
            phase_ff <= (ph_ff == PW'(slc_pkg::PHASES - 1)) ? '0 : ph_ff + PW'(1);
         end
         // Hold the response until taken
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working and response payload
   always_ff @(posedge clock) begin
      ph_ff   <= ph_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      wdbl_ff <= wdbl_in;
      last_ff <= last_in;
      code_ff <= code_in;
      lvl0_ff <= lvl0_in;
      e0_ff   <= e0_in;
      if (load_out) begin
         out_level_ff <= neg_ff ? pick_neg : pick_signed;
         out_code_ff  <= wdbl_ff ? {1'b0, pick_code[IW-1:1]} : pick_code;
         out_sign_ff  <= ~neg_ff;
         out_phase_ff <= ph_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decided_level = signed'(out_level_ff);
   assign rsp_level_code    = out_code_ff;
   assign rsp_sign_bit      = out_sign_ff;
   assign rsp_used_phase    = out_phase_ff;

endmodule

@@ design/slc_level_mem.sv @@
// Level table memory: one write port, one registered read port.
module slc_level_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [slc_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [slc_pkg::LVL_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [slc_pkg::ADDR_W-1:0]  rd_addr,
   output logic [slc_pkg::LVL_W-1:0]   rd_data
);

   logic [slc_pkg::LVL_W-1:0] mem [0:slc_pkg::PHASES*slc_pkg::LEVELS-1];
   logic [slc_pkg::LVL_W-1:0] rd_data_ff;

   // Store a level
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read into the output register; hold when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/slc_abs_diff.sv @@
// Shared compare and distance unit: level >= magnitude and |level - magnitude|.
module slc_abs_diff (
   input  logic [slc_pkg::LVL_W-1:0] level,
   input  logic [slc_pkg::LVL_W-1:0] mag,
   output slc_pkg::diff_type         result
);

   logic [slc_pkg::LVL_W:0] diff;
   logic [slc_pkg::LVL_W:0] diff_neg;

   // Subtract once, take the sign for the compare and fold for the distance
   always_comb begin
      diff       = {1'b0, level} - {1'b0, mag};
      diff_neg   = (~diff) + {{slc_pkg::LVL_W{1'b0}}, 1'b1};
      result.ge  = ~diff[slc_pkg::LVL_W];
      result.gap = result.ge ? diff[slc_pkg::LVL_W-1:0] : diff_neg[slc_pkg::LVL_W-1:0];
   end

endmodule
